@@ rtl/dual_channel_pd_drive_controller_defines.svh @@
// Assertion macros for the two-side PD drive controller.
// Uses the clk and rst names of the module that includes it; no other dependencies.
`ifndef DUAL_CHANNEL_PD_DRIVE_CONTROLLER_DEFINES_SVH
`define DUAL_CHANNEL_PD_DRIVE_CONTROLLER_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define DCPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define DCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dcpd_pkg.sv @@
// Shared widths, constants, codes and command/status types of the PD drive controller.
// No dependencies; every other file but the defines header uses it.
package dcpd_pkg;

  // Position format and target storage
  localparam int POSITION_FRACTION_BITS = 4;
  localparam int TARGET_WIDTH           = 40;

  // Field widths
  localparam int OPCODE_W   = 2;
  localparam int POS_W      = 32;
  localparam int AMOUNT_W   = 17;
  localparam int LDRIVE_W   = 9;
  localparam int RDRIVE_W   = 8;
  localparam int GAIN_W     = 4;
  localparam int LIMIT_W    = 7;
  localparam int WINDOW_W   = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd4;

  // Signed scale constants: Q6.16 move and turn scales, Q2.16 left scale
  localparam int Q_FRAC   = 16;
  localparam int SCALE_W  = 22;
  localparam int LSCALE_W = 18;
  localparam logic signed [SCALE_W-1:0]  MOVE_SCALE = SCALE_W'(1501974);
  localparam logic signed [SCALE_W-1:0]  TURN_SCALE = SCALE_W'(196737);
  localparam logic signed [LSCALE_W-1:0] LEFT_SCALE = LSCALE_W'(66847);
  localparam int ROUND_HALF = 1 << (Q_FRAC - 1);

  // Datapath widths
  localparam int ERR_W   = TARGET_WIDTH + 1;
  localparam int GSUM_W  = GAIN_W + 1;
  localparam int P1_W    = ERR_W + GSUM_W + 1;
  localparam int P2_W    = ERR_W + GAIN_W + 1;
  localparam int V_W     = P1_W + 1;
  localparam int LIM_W   = LIMIT_W + POSITION_FRACTION_BITS;
  localparam int VC_W    = LIM_W + 1;
  localparam int MPROD_W = AMOUNT_W + SCALE_W;
  localparam int INC_W   = MPROD_W + 1 - Q_FRAC;
  localparam int LP_W    = VC_W + LSCALE_W;
  localparam int LSHIFT  = Q_FRAC + POSITION_FRACTION_BITS;
  localparam int LMASK   = (1 << LSHIFT) - 1;
  localparam int RMASK   = (1 << POSITION_FRACTION_BITS) - 1;

  // Request opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_TURN = 2'd2
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MRND,
    ST_MADD,
    ST_MUL,
    ST_SUM,
    ST_FIN
  } state_t;

  // Configuration register set
  typedef struct packed {
    logic                manual_override;
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   deriv_gain;
    logic [LIMIT_W-1:0]  drive_limit;
    logic [WINDOW_W-1:0] reach_window;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_tick;
    logic load_move;
    logic round;
    logic update;
    logic mul;
    logic sum;
    logic fin;
    logic drive_on;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic res_free;
  } sts_t;

endpackage

@@ rtl/dcpd_if.sv @@
// Request and result channel interfaces of the PD drive controller.
// Depends on dcpd_pkg for field widths.
interface dcpd_req_if;
  import dcpd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [POS_W-1:0]    left_position;
  logic signed [POS_W-1:0]    right_position;
  logic signed [AMOUNT_W-1:0] amount;

  modport source (output valid, opcode, left_position, right_position, amount, input ready);
  modport sink   (input valid, opcode, left_position, right_position, amount, output ready);
  modport mon    (input valid, ready, opcode, left_position, right_position, amount);
endinterface

interface dcpd_res_if;
  import dcpd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [LDRIVE_W-1:0] left_drive;
  logic signed [RDRIVE_W-1:0] right_drive;
  logic                       drive_valid;
  logic                       target_reached;

  modport source (output valid, left_drive, right_drive, drive_valid, target_reached,
                  input ready);
  modport sink   (input valid, left_drive, right_drive, drive_valid, target_reached,
                  output ready);
  modport mon    (input valid, ready, left_drive, right_drive, drive_valid, target_reached);
endinterface

@@ rtl/dcpd_cfg.sv @@
// Configuration register file of the PD drive controller.
// Depends on dcpd_pkg for the register indexes and the cfg_t type.
module dcpd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [dcpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dcpd_pkg::cfg_t                   cfg
);
  import dcpd_pkg::*;

  // Write one register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.manual_override <= 1'b0;
      cfg.prop_gain       <= GAIN_W'(2);
      cfg.deriv_gain      <= GAIN_W'(2);
      cfg.drive_limit     <= LIMIT_W'(70);
      cfg.reach_window    <= WINDOW_W'(120);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OVERRIDE: cfg.manual_override <= cfg_data[0];
        REG_PROP:     cfg.prop_gain       <= cfg_data[GAIN_W-1:0];
        REG_DERIV:    cfg.deriv_gain      <= cfg_data[GAIN_W-1:0];
        REG_LIMIT:    cfg.drive_limit     <= cfg_data[LIMIT_W-1:0];
        REG_WINDOW:   cfg.reach_window    <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/dcpd_ctrl.sv @@
// Sequencing state machine of the PD drive controller.
// Depends on dcpd_pkg for state, opcode, command and status types.
module dcpd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [dcpd_pkg::OPCODE_W-1:0] opcode,
  input  logic                          manual_override,
  input  dcpd_pkg::sts_t                sts,
  output logic                          req_ready,
  output dcpd_pkg::cmd_t                cmd
);
  import dcpd_pkg::*;

  state_t state, state_next;
  logic   drive_on, drive_on_next;

  // State register and loop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      drive_on <= 1'b0;
    end else begin
      state    <= state_next;
      drive_on <= drive_on_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    drive_on_next = drive_on;
    cmd           = '0;
    req_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (opcode)
            OP_TICK: begin
              cmd.load_tick = 1'b1;
              drive_on_next = !manual_override;
              state_next    = manual_override ? ST_FIN : ST_MUL;
            end
            OP_MOVE, OP_TURN: begin
              cmd.load_move = 1'b1;
              state_next    = ST_MRND;
            end
            default: ;
          endcase
        end
      end
      ST_MRND: begin
        cmd.round  = 1'b1;
        state_next = ST_MADD;
      end
      ST_MADD: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold here until the result register can take the new result
        cmd.drive_on = drive_on;
        if (sts.res_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/dcpd_dp.sv @@
// Datapath of the PD drive controller: targets, errors, PD products, clamp,
// left scaling and the result register. Depends on dcpd_pkg.
module dcpd_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dcpd_pkg::cmd_t                       cmd,
  input  dcpd_pkg::cfg_t                       cfg,
  input  logic [dcpd_pkg::OPCODE_W-1:0]        opcode,
  input  logic signed [dcpd_pkg::POS_W-1:0]    left_position,
  input  logic signed [dcpd_pkg::POS_W-1:0]    right_position,
  input  logic signed [dcpd_pkg::AMOUNT_W-1:0] amount,
  input  logic                                 res_ready,
  output logic                                 res_valid,
  output logic signed [dcpd_pkg::LDRIVE_W-1:0] left_drive,
  output logic signed [dcpd_pkg::RDRIVE_W-1:0] right_drive,
  output logic                                 drive_valid,
  output logic                                 target_reached,
  output dcpd_pkg::sts_t                       sts
);
  import dcpd_pkg::*;

  // Clamp a PD sum to plus or minus the drive limit in 1/16 units
  function automatic logic signed [VC_W-1:0] clamp_drive(
    input logic signed [V_W-1:0]   v,
    input logic [LIMIT_W-1:0]      lim
  );
    logic signed [V_W-1:0] hi;
    hi = $signed(V_W'({lim, {POSITION_FRACTION_BITS{1'b0}}}));
    if (v > hi)
      return VC_W'(hi);
    else if (v < -hi)
      return VC_W'(-hi);
    else
      return VC_W'(v);
  endfunction

  // Persistent state
  logic signed [TARGET_WIDTH-1:0] left_target, right_target;
  logic signed [ERR_W-1:0]        left_last_err, right_last_err;

  // Move path
  logic signed [MPROD_W-1:0] mv_prod, mv_prod_next;
  logic signed [MPROD_W:0]   mv_biased;
  logic signed [INC_W-1:0]   mv_inc;
  logic                      mv_turn;
  logic signed [TARGET_WIDTH-1:0] mv_step;

  // Tick path
  logic signed [ERR_W-1:0] lerr, rerr;
  logic [GSUM_W-1:0]       gsum;
  logic signed [P1_W-1:0]  lp1, rp1, lp1_next, rp1_next;
  logic signed [P2_W-1:0]  lp2, rp2, lp2_next, rp2_next;
  logic signed [V_W-1:0]   lv, rv;
  logic signed [VC_W-1:0]  lvc, rvc;
  logic signed [LP_W-1:0]  lprod, lbias;
  logic signed [VC_W-1:0]  rbias;
  logic signed [ERR_W-1:0] win;
  logic                    reached;

  // Move increment: scaled amount, rounded half up
  assign mv_prod_next = $signed(amount) * ((opcode == OP_MOVE) ? MOVE_SCALE : TURN_SCALE);
  assign mv_biased    = {mv_prod[MPROD_W-1], mv_prod} + (MPROD_W+1)'(ROUND_HALF);
  assign mv_step      = TARGET_WIDTH'(mv_inc);

  // PD products: (kp + kd) * e - kd * last error
  assign gsum     = {1'b0, cfg.prop_gain} + {1'b0, cfg.deriv_gain};
  assign lp1_next = lerr * $signed({1'b0, gsum});
  assign rp1_next = rerr * $signed({1'b0, gsum});
  assign lp2_next = left_last_err * $signed({1'b0, cfg.deriv_gain});
  assign rp2_next = right_last_err * $signed({1'b0, cfg.deriv_gain});
  assign lv       = V_W'(lp1) - V_W'(lp2);
  assign rv       = V_W'(rp1) - V_W'(rp2);

  // Output scaling, truncated toward zero
  assign lprod = lvc * LEFT_SCALE;
  assign lbias = lprod + (lprod[LP_W-1] ? LP_W'(LMASK) : '0);
  assign rbias = rvc + (rvc[VC_W-1] ? VC_W'(RMASK) : '0);

  // Both held errors strictly inside the window
  assign win     = $signed(ERR_W'(cfg.reach_window));
  assign reached = (left_last_err < win) && (left_last_err > -win) &&
                   (right_last_err < win) && (right_last_err > -win);

  assign sts.res_free = !res_valid || res_ready;

  // Targets and held errors
  always_ff @(posedge clk) begin
    if (rst) begin
      left_target    <= '0;
      right_target   <= '0;
      left_last_err  <= '0;
      right_last_err <= '0;
    end else begin
      if (cmd.update) begin
        left_target  <= left_target + mv_step;
        right_target <= mv_turn ? right_target - mv_step : right_target + mv_step;
      end
      if (cmd.sum) begin
        left_last_err  <= lerr;
        right_last_err <= rerr;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_move) begin
      mv_prod <= mv_prod_next;
      mv_turn <= (opcode == OP_TURN);
    end
    if (cmd.round)
      mv_inc <= mv_biased[MPROD_W:Q_FRAC];
    if (cmd.load_tick) begin
      lerr <= ERR_W'(left_target) - ERR_W'(left_position);
      rerr <= ERR_W'(right_target) - ERR_W'(right_position);
    end
    if (cmd.mul) begin
      lp1 <= lp1_next;
      rp1 <= rp1_next;
      lp2 <= lp2_next;
      rp2 <= rp2_next;
    end
    if (cmd.sum) begin
      lvc <= clamp_drive(lv, cfg.drive_limit);
      rvc <= clamp_drive(rv, cfg.drive_limit);
    end
  end

  // Result register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst)
      res_valid <= 1'b0;
    else if (cmd.fin)
      res_valid <= 1'b1;
    else if (res_ready)
      res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      left_drive     <= cmd.drive_on ? lbias[LSHIFT+LDRIVE_W-1:LSHIFT] : '0;
      right_drive    <= cmd.drive_on ?
                        rbias[POSITION_FRACTION_BITS+RDRIVE_W-1:POSITION_FRACTION_BITS] : '0;
      drive_valid    <= cmd.drive_on;
      target_reached <= reached;
    end
  end

endmodule

@@ rtl/dual_channel_pd_drive_controller.sv @@
// Top level of the two-side PD drive controller.
// Depends on dcpd_pkg, dcpd_if, dcpd_cfg, dcpd_ctrl and dcpd_dp.
//
//   Channel | Role   | Handshake       | Carries
//   req     | sink   | valid / ready   | opcode, left/right position, amount
//   res     | source | valid / ready   | left/right drive, drive_valid, target_reached
//   cfg     | input  | cfg_write only  | cfg_index, cfg_data
//
// One request at a time. A loop tick: accept, multiply, sum and clamp, scale into
// the result register; an override tick: accept, then the result register; move
// and turn: multiply, round, add to targets; an unused opcode is only accepted.
// The PD products and the left scaling multiplier each sit in their own state.
// Reset is synchronous and clears targets, held errors, res.valid, state and cfg.
// A result waiting in the result register does not block the next request; the
// finish state stalls only when a second result is ready before the first is taken.
module dual_channel_pd_drive_controller (
  input  logic                            clk,
  input  logic                            rst,
  dcpd_req_if.sink                        req,
  dcpd_res_if.source                      res,
  input  logic                            cfg_write,
  input  logic [dcpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dcpd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers
  dcpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer
  dcpd_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req.valid),
    .opcode          (req.opcode),
    .manual_override (cfg.manual_override),
    .sts             (sts),
    .req_ready       (req.ready),
    .cmd             (cmd)
  );

  // Arithmetic and result register
  dcpd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .opcode         (req.opcode),
    .left_position  (req.left_position),
    .right_position (req.right_position),
    .amount         (req.amount),
    .res_ready      (res.ready),
    .res_valid      (res.valid),
    .left_drive     (res.left_drive),
    .right_drive    (res.right_drive),
    .drive_valid    (res.drive_valid),
    .target_reached (res.target_reached),
    .sts            (sts)
  );

endmodule

@@ rtl/dcpd_checker.sv @@
// Port-level checks on the result channel of the PD drive controller, bound to the top.
// Depends on the defines header and dcpd_pkg for the drive widths.
`include "dual_channel_pd_drive_controller_defines.svh"

module dcpd_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 res_valid,
  input logic                                 res_ready,
  input logic signed [dcpd_pkg::LDRIVE_W-1:0] left_drive,
  input logic signed [dcpd_pkg::RDRIVE_W-1:0] right_drive,
  input logic                                 drive_valid,
  input logic                                 target_reached
);

  // A stalled result holds its drives
  `DCPD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(left_drive) && $stable(right_drive), "result changed while stalled")

  // No drive under override
  `DCPD_ASSERT_SAME(a_override_zero, res_valid && !drive_valid, left_drive == 0 && right_drive == 0, "drive present without drive_valid")

  // Clamp bounds on both drives
  `DCPD_ASSERT_SAME(a_drive_range, res_valid, right_drive >= -8'sd127 && left_drive <= 9'sd129 && left_drive >= -9'sd129, "drive outside clamp range")

  // A stalled result holds its flags
  `DCPD_ASSERT_NEXT(a_flag_hold, res_valid && !res_ready, $stable(drive_valid) && $stable(target_reached), "result flags changed while stalled")

endmodule

bind dual_channel_pd_drive_controller dcpd_checker u_dcpd_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .left_drive     (res.left_drive),
  .right_drive    (res.right_drive),
  .drive_valid    (res.drive_valid),
  .target_reached (res.target_reached)
);

@@ verif/dual_channel_pd_drive_controller_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the two-side PD drive controller: bursty request driver,
// stalling result receiver, and an in-bench controller model that predicts each drive.
// Depends on dcpd_pkg, the dcpd_req_if / dcpd_res_if interfaces and the RTL top level.
module dual_channel_pd_drive_controller_test;
  import dcpd_pkg::*;

  localparam logic [OPCODE_W-1:0]  OP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint MOVE_Q16  = 1501974;
  localparam longint TURN_Q16  = 196737;
  localparam longint LEFT_Q16  = 66847;
  localparam longint HALF_Q16  = 32768;
  localparam longint POS_MAX   = 64'sh7FFF_FFFF;
  localparam longint POS_MIN   = -POS_MAX - 1;
  localparam longint AMT_MAX   = 65535;
  localparam longint AMT_MIN   = -65536;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 15;
  localparam int PHASE_ITEMS    = 76;

  typedef struct packed {
    logic [OPCODE_W-1:0]        opcode;
    logic signed [POS_W-1:0]    left_position;
    logic signed [POS_W-1:0]    right_position;
    logic signed [AMOUNT_W-1:0] amount;
  } request_t;

  typedef struct packed {
    logic signed [LDRIVE_W-1:0] left_drive;
    logic signed [RDRIVE_W-1:0] right_drive;
    logic                       drive_valid;
    logic                       target_reached;
  } drive_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dcpd_req_if req_ch();
  dcpd_res_if res_ch();

  dual_channel_pd_drive_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Controller model state and register copy, reset values
  logic signed [TARGET_WIDTH-1:0] tgt_left  = '0;
  logic signed [TARGET_WIDTH-1:0] tgt_right = '0;
  logic signed [ERR_W-1:0]        err_left  = '0;
  logic signed [ERR_W-1:0]        err_right = '0;
  logic                           cfg_override = 1'b0;
  logic [GAIN_W-1:0]              cfg_prop     = 4'd2;
  logic [GAIN_W-1:0]              cfg_deriv    = 4'd2;
  logic [LIMIT_W-1:0]             cfg_limit    = 7'd70;
  logic [WINDOW_W-1:0]            cfg_window   = 12'd120;

  request_t      pending[$];
  drive_result_t expected_drives[$];

  // Planning shadow: where the targets will be once queued requests are taken
  longint plan_lt = 0, plan_rt = 0, plan_lp = 0, plan_rp = 0;
  int     planned = 0;

  int         burst_left = 0;
  int         gap_left = 0;
  logic       req_taken;
  logic [7:0] pace_pattern = 8'hFF;
  int         pace_count = 0;
  int         fault_count = 0;
  int         stall_cycles = 0;

  // Target step for a move or turn, Q16 product rounded half up
  function automatic longint target_increment(logic [OPCODE_W-1:0] op,
                                              logic signed [AMOUNT_W-1:0] amt);
    longint scale;
    scale = (op == OP_MOVE) ? MOVE_Q16 : TURN_Q16;
    return (longint'(amt) * scale + HALF_Q16) >>> 16;
  endfunction

  function automatic longint toward_zero(longint v, int sh);
    return (v >= 0) ? (v >>> sh) : -((-v) >>> sh);
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Advance the model by one accepted request and, for a tick, queue the drive it produces
  function automatic void compute_drive(request_t rq);
    longint inc, le, re, lv, rv, lim;
    drive_result_t r;
    if (rq.opcode == OP_MOVE || rq.opcode == OP_TURN) begin
      inc = target_increment(rq.opcode, rq.amount);
      tgt_left = TARGET_WIDTH'(longint'(tgt_left) + inc);
      if (rq.opcode == OP_MOVE) tgt_right = TARGET_WIDTH'(longint'(tgt_right) + inc);
      else tgt_right = TARGET_WIDTH'(longint'(tgt_right) - inc);
    end else if (rq.opcode == OP_TICK) begin
      r = '0;
      if (!cfg_override) begin
        le  = longint'(tgt_left) - longint'(rq.left_position);
        re  = longint'(tgt_right) - longint'(rq.right_position);
        lv  = longint'(cfg_prop) * le + longint'(cfg_deriv) * (le - longint'(err_left));
        rv  = longint'(cfg_prop) * re + longint'(cfg_deriv) * (re - longint'(err_right));
        lim = longint'(cfg_limit) <<< POSITION_FRACTION_BITS;
        lv  = (lv > lim) ? lim : ((lv < -lim) ? -lim : lv);
        rv  = (rv > lim) ? lim : ((rv < -lim) ? -lim : rv);
        r.left_drive  = LDRIVE_W'(toward_zero(lv * LEFT_Q16, 16 + POSITION_FRACTION_BITS));
        r.right_drive = RDRIVE_W'(toward_zero(rv, POSITION_FRACTION_BITS));
        r.drive_valid = 1'b1;
        err_left  = ERR_W'(le);
        err_right = ERR_W'(re);
      end
      r.target_reached = (magnitude(longint'(err_left)) < longint'(cfg_window)) &&
                         (magnitude(longint'(err_right)) < longint'(cfg_window));
      expected_drives.push_back(r);
    end
  endfunction

  task automatic report_fault(string msg);
    if (fault_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    fault_count = fault_count + 1;
  endtask

  // Queue a request and keep the planning shadow in step with it
  function automatic void plan_request(logic [OPCODE_W-1:0] op, longint lp, longint rp,
                                       longint amt);
    request_t rq;
    rq.opcode         = op;
    rq.left_position  = POS_W'(lp);
    rq.right_position = POS_W'(rp);
    rq.amount         = AMOUNT_W'(amt);
    pending.push_back(rq);
    if (op == OP_MOVE || op == OP_TURN) begin
      plan_lt = plan_lt + target_increment(op, rq.amount);
      if (op == OP_MOVE) plan_rt = plan_rt + target_increment(op, rq.amount);
      else plan_rt = plan_rt - target_increment(op, rq.amount);
    end
    if (op != OP_UNUSED) planned = planned + 1;
  endfunction

  // Tick with the wheels closing half the remaining error, or landing on target
  function automatic void plan_tick(int jitter, bit land);
    longint jl, jr;
    jl = longint'($urandom_range(0, 2 * jitter)) - jitter;
    jr = longint'($urandom_range(0, 2 * jitter)) - jitter;
    if (land) begin
      plan_lp = plan_lt;
      plan_rp = plan_rt;
    end else begin
      plan_lp = plan_lp + (plan_lt - plan_lp) / 2 + jl;
      plan_rp = plan_rp + (plan_rt - plan_rp) / 2 + jr;
    end
    plan_request(OP_TICK, plan_lp, plan_rp, longint'($urandom()));
  endfunction

  // Tick with both errors at the reach window or one step either side of it
  function automatic void plan_window_edge();
    longint ol, orr;
    ol  = longint'(cfg_window) + longint'($urandom_range(0, 2)) - 1;
    orr = longint'(cfg_window) + longint'($urandom_range(0, 2)) - 1;
    if ($urandom_range(0, 1)) ol = -ol;
    if ($urandom_range(0, 1)) orr = -orr;
    plan_lp = plan_lt - ol;
    plan_rp = plan_rt - orr;
    plan_request(OP_TICK, plan_lp, plan_rp, longint'($urandom()));
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_OVERRIDE: cfg_override = data[0];
      REG_PROP:     cfg_prop     = data[GAIN_W-1:0];
      REG_DERIV:    cfg_deriv    = data[GAIN_W-1:0];
      REG_LIMIT:    cfg_limit    = data[LIMIT_W-1:0];
      REG_WINDOW:   cfg_window   = data[WINDOW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold until every queued request is taken and every drive has come back
  task automatic drain_requests();
    while (pending.size() != 0 || req_ch.valid || expected_drives.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver: bursts of random length separated by random gaps
  always @(negedge clk) begin : feed_requests
    request_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (gap_left > 0 || pending.size() == 0) begin
        if (gap_left > 0) gap_left = gap_left - 1;
        req_ch.valid <= 1'b0;
      end else begin
        nxt = pending.pop_front();
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= nxt.opcode;
        req_ch.left_position  <= nxt.left_position;
        req_ch.right_position <= nxt.right_position;
        req_ch.amount         <= nxt.amount;
        // close the burst and choose the gap after it
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // Result receiver: replay an 8-bit ready pattern, drawn afresh after 2 to 8 passes
  always @(negedge clk) begin : pace_results
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (pace_count == 0) begin
        pace_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
        pace_count   = 8 * $urandom_range(2, 8);
      end
      pace_count = pace_count - 1;
      res_ch.ready <= pace_pattern[pace_count % 8];
    end
  end

  // Sample both channels: check drives, advance the model, watch for a hang
  always @(posedge clk) begin : watch_channels
    request_t      rq;
    drive_result_t want;
    if (rst) begin
      req_taken    <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_drives.size() == 0) begin
          report_fault("drive result with no request outstanding");
        end else begin
          want = expected_drives.pop_front();
          if (res_ch.left_drive !== want.left_drive)
            report_fault($sformatf("left_drive %0d, expected %0d",
                                   res_ch.left_drive, want.left_drive));
          if (res_ch.right_drive !== want.right_drive)
            report_fault($sformatf("right_drive %0d, expected %0d",
                                   res_ch.right_drive, want.right_drive));
          if (res_ch.drive_valid !== want.drive_valid)
            report_fault($sformatf("drive_valid %b, expected %b",
                                   res_ch.drive_valid, want.drive_valid));
          if (res_ch.target_reached !== want.target_reached)
            report_fault($sformatf("target_reached %b, expected %b",
                                   res_ch.target_reached, want.target_reached));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        rq.opcode         = req_ch.opcode;
        rq.left_position  = req_ch.left_position;
        rq.right_position = req_ch.right_position;
        rq.amount         = req_ch.amount;
        compute_drive(rq);
      end
      req_taken <= req_ch.valid && req_ch.ready;
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic                ov;
    logic [GAIN_W-1:0]   kp, kd;
    logic [LIMIT_W-1:0]  lim;
    logic [WINDOW_W-1:0] win;
    int                  goal, pick, steps;

    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.opcode         = '0;
    req_ch.left_position  = '0;
    req_ch.right_position = '0;
    req_ch.amount         = '0;
    res_ch.ready          = 1'b0;
    cfg_write             = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under reset settings: first tick with zero held errors,
    // saturating positions, extreme and tie-rounding amounts, unused opcode
    plan_request(OP_TICK, 0, 0, AMT_MIN);
    plan_request(OP_TICK, POS_MAX, POS_MIN, AMT_MAX);
    plan_request(OP_TICK, POS_MIN, POS_MAX, -1);
    plan_request(OP_MOVE, longint'($urandom()), longint'($urandom()), AMT_MAX);
    plan_tick(0, 1'b1);
    plan_request(OP_MOVE, longint'($urandom()), longint'($urandom()), AMT_MIN);
    plan_request(OP_TURN, longint'($urandom()), longint'($urandom()), AMT_MAX);
    plan_request(OP_TURN, longint'($urandom()), longint'($urandom()), AMT_MIN);
    plan_request(OP_MOVE, 0, 0, 16384);
    plan_request(OP_MOVE, 0, 0, -16384);
    plan_request(OP_TURN, 0, 0, 32768);
    plan_request(OP_TURN, 0, 0, -32768);
    plan_tick(0, 1'b1);
    plan_request(OP_UNUSED, -1, -1, -1);
    plan_request(OP_UNUSED, 0, 0, 0);
    plan_request(OP_TURN, -1, -1, 1);
    plan_request(OP_MOVE, -1, -1, -1);
    repeat (3) plan_tick(3, 1'b0);
    repeat (3) plan_window_edge();

    for (int p = 1; p <= PHASES; p++) begin
      drain_requests();
      // Register set for this phase: extremes first, then random
      ov = (p % 5 == 3);
      case (p)
        1: begin
          kp = '0; kd = '0; lim = '0; win = '0;
        end
        2: begin
          kp = '1; kd = '1; lim = '1; win = '1;
        end
        4: begin
          kp = 4'($urandom()); kd = 4'($urandom()); lim = 7'($urandom()); win = 12'd1;
        end
        default: begin
          kp  = 4'($urandom());
          kd  = 4'($urandom());
          lim = 7'($urandom());
          win = ($urandom_range(0, 3) == 0) ? 12'($urandom()) : 12'($urandom_range(4, 300));
        end
      endcase
      write_register(REG_OVERRIDE, {11'($urandom()), ov});
      write_register(REG_PROP, {8'($urandom()), kp});
      write_register(REG_DERIV, {8'($urandom()), kd});
      write_register(REG_LIMIT, {5'($urandom()), lim});
      write_register(REG_WINDOW, win);
      if (p % 4 == 1)
        write_register(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 12'($urandom()));

      goal = planned + PHASE_ITEMS;
      while (planned < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // well-formed approach: a move or turn, then ticks that close in on it
          if ($urandom_range(0, 3) == 0)
            plan_request($urandom_range(0, 2) == 0 ? OP_TURN : OP_MOVE,
                         longint'($urandom()), longint'($urandom()),
                         longint'($urandom_range(0, 131071)) + AMT_MIN);
          else
            plan_request($urandom_range(0, 2) == 0 ? OP_TURN : OP_MOVE,
                         longint'($urandom()), longint'($urandom()),
                         longint'($urandom_range(0, 8191)) - 4096);
          steps = $urandom_range(2, 10);
          repeat (steps - 1) plan_tick($urandom_range(0, 4), 1'b0);
          plan_tick($urandom_range(0, 4), $urandom_range(0, 1));
        end else if (pick < 78) begin
          plan_request(OP_TICK, longint'($urandom()), longint'($urandom()),
                       longint'($urandom()));
        end else if (pick < 82) begin
          plan_request(OP_UNUSED, longint'($urandom()), longint'($urandom()),
                       longint'($urandom()));
        end else if (pick < 90) begin
          plan_window_edge();
        end else begin
          plan_request($urandom_range(0, 1) ? OP_TURN : OP_MOVE,
                       longint'($urandom()), longint'($urandom()),
                       longint'($urandom_range(0, 131071)) + AMT_MIN);
        end
      end
    end

    drain_requests();
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
